/* sv/tlfd_pkg.sv */
package tlfd_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_FAILED  = 2'd2;

  // frame channels
  localparam logic [1:0] CH_COMMAND = 2'd0;
  localparam logic [1:0] CH_DATA    = 2'd1;
  localparam logic [1:0] CH_HELLO   = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_CHANNEL   = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
  localparam logic [2:0] ERR_NOT_FIRST = 3'd3;
  localparam logic [2:0] ERR_REPEATED  = 3'd4;
  localparam logic [2:0] ERR_HELLO_LEN = 3'd5;
  localparam logic [2:0] ERR_VERSION   = 3'd6;

  // header byte counter
  localparam logic [2:0] HDR_FIRST   = 3'd0;
  localparam logic [2:0] HDR_LAST    = 3'd4;
  localparam logic [2:0] HDR_PAYLOAD = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HELLO_CODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 3'd3;

  // configuration reset values
  localparam logic [7:0] RST_HELLO_CODE   = 8'd0;
  localparam logic [7:0] RST_COMMAND_CODE = 8'd1;
  localparam logic [7:0] RST_DATA_CODE    = 8'd2;
  localparam logic [7:0] RST_VERSION      = 8'd1;

  // one hello frame carries exactly one byte
  localparam logic [31:0] HELLO_LEN = 32'd1;

  typedef struct packed {
    logic [7:0] hello_code;
    logic [7:0] command_code;
    logic [7:0] data_code;
    logic [7:0] protocol_version;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] frame_channel;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic [2:0] error_code;
    logic       hello_seen;
  } result_t;

endpackage

/* sv/tlfd_stage.sv */
module tlfd_stage #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         valid;
  logic [W-1:0] data;

  // take a new request whenever the held one leaves or there is none
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

/* sv/tlfd_parse.sv */
module tlfd_parse #(
  parameter int unsigned MAX_PAYLOAD = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  tlfd_pkg::cfg_t    cfg,
  output tlfd_pkg::result_t res
);
  import tlfd_pkg::*;

  localparam int unsigned   RW      = $clog2(MAX_PAYLOAD + 1);
  localparam logic [31:0]   MAX_LEN = 32'(MAX_PAYLOAD);
  localparam logic [RW-1:0] REM_ONE = RW'(1);

  logic [2:0]    header_count, header_count_next;
  logic [7:0]    raw_channel, raw_channel_next;
  logic [31:0]   length_shift, length_shift_next;
  logic [RW-1:0] bytes_remaining, bytes_remaining_next;
  logic [1:0]    channel_kind, channel_kind_next;
  logic          hello_done, hello_done_next;
  logic          failed_flag, failed_flag_next;
  logic [2:0]    stored_error, stored_error_next;

  logic [31:0]   len_new;
  logic [RW-1:0] rem_dec;
  logic [1:0]    ch_new;
  logic          ch_known;
  logic          fail_en;
  logic [2:0]    fail_code;

  assign len_new = {length_shift[23:0], in_byte};
  assign rem_dec = (bytes_remaining != '0) ? bytes_remaining - REM_ONE : bytes_remaining;

  // channel match, hello first, then command, then data
  always_comb begin
    ch_known = 1'b1;
    ch_new   = CH_COMMAND;
    priority if (raw_channel == cfg.hello_code) begin
      ch_new = CH_HELLO;
    end else if (raw_channel == cfg.command_code) begin
      ch_new = CH_COMMAND;
    end else if (raw_channel == cfg.data_code) begin
      ch_new = CH_DATA;
    end else begin
      ch_known = 1'b0;
    end
  end

  // next state and result for one byte
  always_comb begin
    header_count_next    = header_count;
    raw_channel_next     = raw_channel;
    length_shift_next    = length_shift;
    bytes_remaining_next = bytes_remaining;
    channel_kind_next    = channel_kind;
    hello_done_next      = hello_done;
    failed_flag_next     = failed_flag;
    stored_error_next    = stored_error;
    fail_en              = 1'b0;
    fail_code            = ERR_NONE;
    res                  = '0;
    res.kind             = KIND_HEADER;

    if (failed_flag) begin
      fail_en   = 1'b1;
      fail_code = stored_error;
    end else if (header_count < HDR_PAYLOAD) begin
      header_count_next = header_count + 3'd1;
      if (header_count == HDR_FIRST) begin
        raw_channel_next  = in_byte;
        length_shift_next = '0;
      end else begin
        length_shift_next = len_new;
      end
      // header check at the fifth byte
      if (header_count == HDR_LAST) begin
        if (!ch_known) begin
          fail_en   = 1'b1;
          fail_code = ERR_CHANNEL;
        end else begin
          channel_kind_next = ch_new;
          priority if (len_new > MAX_LEN) begin
            fail_en   = 1'b1;
            fail_code = ERR_TOO_LONG;
          end else if (!hello_done && ch_new != CH_HELLO) begin
            fail_en   = 1'b1;
            fail_code = ERR_NOT_FIRST;
          end else if (hello_done && ch_new == CH_HELLO) begin
            fail_en   = 1'b1;
            fail_code = ERR_REPEATED;
          end else if (ch_new == CH_HELLO && len_new != HELLO_LEN) begin
            fail_en   = 1'b1;
            fail_code = ERR_HELLO_LEN;
          end else if (len_new == '0) begin
            header_count_next = HDR_FIRST;
            res.frame_end     = 1'b1;
          end else begin
            bytes_remaining_next = len_new[RW-1:0];
          end
        end
      end
    end else begin
      // payload phase
      if (channel_kind == CH_HELLO && in_byte != cfg.protocol_version) begin
        fail_en   = 1'b1;
        fail_code = ERR_VERSION;
      end else begin
        bytes_remaining_next = rem_dec;
        res.kind             = KIND_PAYLOAD;
        res.payload_byte     = in_byte;
        if (rem_dec == '0) begin
          header_count_next = HDR_FIRST;
          res.frame_end     = 1'b1;
          if (channel_kind == CH_HELLO) begin
            hello_done_next = 1'b1;
          end
        end
      end
    end

    if (fail_en) begin
      failed_flag_next  = 1'b1;
      stored_error_next = fail_code;
      res.kind          = KIND_FAILED;
      res.payload_byte  = '0;
      res.frame_end     = 1'b0;
      res.error_code    = fail_code;
    end
    res.frame_channel = channel_kind_next;
    res.hello_seen    = hello_done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count    <= HDR_FIRST;
      raw_channel     <= '0;
      length_shift    <= '0;
      bytes_remaining <= '0;
      channel_kind    <= CH_COMMAND;
      hello_done      <= 1'b0;
      failed_flag     <= 1'b0;
      stored_error    <= ERR_NONE;
    end else if (step) begin
      header_count    <= header_count_next;
      raw_channel     <= raw_channel_next;
      length_shift    <= length_shift_next;
      bytes_remaining <= bytes_remaining_next;
      channel_kind    <= channel_kind_next;
      hello_done      <= hello_done_next;
      failed_flag     <= failed_flag_next;
      stored_error    <= stored_error_next;
    end
  end

endmodule

/* sv/type_length_frame_deframer_unit.sv */
// each accepted byte is held in the input register, and its result is held in the result register
// throughput: one byte per cycle, sustained when the output side keeps up
// the rate is set by the input and result registers, which both advance while the output side keeps up
// reset (rst, synchronous, active high) clears the parser state and the stages
// and returns the channel codes and version to their defaults
module type_length_frame_deframer_unit #(
  parameter int unsigned MAX_PAYLOAD = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  // stream in
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] in_byte
  // stream out
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // [1:0] frame_channel, [9:2] payload_byte,
                                                    // [12:10] error_code, [13] hello_seen
  output logic [1:0]                     m_tuser,   // [1:0] kind
  output logic                           m_tlast,   // frame_end
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import tlfd_pkg::*;

  localparam int unsigned RES_W = $bits(result_t);

  cfg_t       cfg;
  result_t    res, res_q;
  logic       in_valid, in_ready_int;
  logic [7:0] in_byte;
  logic       out_ready;
  logic       step;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hello_code       <= RST_HELLO_CODE;
      cfg.command_code     <= RST_COMMAND_CODE;
      cfg.data_code        <= RST_DATA_CODE;
      cfg.protocol_version <= RST_VERSION;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HELLO_CODE:   cfg.hello_code       <= cfg_data;
        CFG_COMMAND_CODE: cfg.command_code     <= cfg_data;
        CFG_DATA_CODE:    cfg.data_code        <= cfg_data;
        CFG_VERSION:      cfg.protocol_version <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  tlfd_stage #(.W(8)) u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (in_ready_int),
    .in_data   (s_tdata),
    .out_valid (in_valid),
    .out_ready (out_ready),
    .out_data  (in_byte)
  );

  assign s_tready = in_ready_int;
  assign step     = in_valid && out_ready;

  // header and payload parsing
  tlfd_parse #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  tlfd_stage #(.W(RES_W)) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (out_ready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_q)
  );

  // pack the result onto the stream
  assign m_tuser = res_q.kind;
  assign m_tlast = res_q.frame_end;
  assign m_tdata = {2'b00, res_q.hello_seen, res_q.error_code,
                    res_q.payload_byte, res_q.frame_channel};

endmodule

/* sv/tlfd_checker.sv */
module tlfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import tlfd_pkg::*;

  // a failure result always carries an error, and only a failure does
  a_err_iff_failed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == KIND_FAILED) == (m_tdata[12:10] != ERR_NONE)))
    else $error("error code and failed kind disagree");

  // payload byte is zero unless the result is a payload byte
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_PAYLOAD |-> m_tdata[9:2] == 8'd0)
    else $error("payload byte set outside payload");

  // a failed decoder never completes a frame
  a_no_end_on_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser != KIND_FAILED)
    else $error("frame end on a failed result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind type_length_frame_deframer_unit tlfd_checker u_tlfd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

/* verif/deframe_monitor.sv */
`timescale 1ns / 100ps

module deframe_monitor #(
  parameter int unsigned MAX_PAYLOAD = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [15:0]                    m_tdata,
  input  logic [1:0]                     m_tuser,
  input  logic                           m_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tlfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int                             fail_count,
  output int                             outstanding
);
  import tlfd_pkg::*;

  localparam int unsigned LEFT_W = $clog2(MAX_PAYLOAD + 1);

  // channel codes and version as last written
  logic [7:0] code_hello;
  logic [7:0] code_cmd;
  logic [7:0] code_data;
  logic [7:0] want_ver;

  // parser state
  logic [2:0]        hdr_cnt;
  logic [7:0]        chan_raw;
  logic [31:0]       len_acc;
  logic [LEFT_W-1:0] left_cnt;
  logic [1:0]        cur_chan;
  logic              hello_ok;
  logic              dead;
  logic [2:0]        dead_code;

  // results owed by the block, oldest first
  result_t due_results[$];

  // advance the parser by one stream byte and build the result it owes
  task automatic parse_byte(input logic [7:0] b, output result_t r);
    logic [2:0] fault;
    fault = ERR_NONE;
    r = '0;
    r.kind = KIND_HEADER;
    if (dead) begin
      fault = dead_code;
    end else if (hdr_cnt < HDR_PAYLOAD) begin
      if (hdr_cnt == HDR_FIRST) begin
        chan_raw = b;
        len_acc = '0;
      end else begin
        len_acc = {len_acc[23:0], b};
      end
      hdr_cnt = hdr_cnt + 3'd1;
      if (hdr_cnt == HDR_PAYLOAD) begin
        // hello wins over command, command over data
        if (chan_raw == code_hello) begin
          cur_chan = CH_HELLO;
        end else if (chan_raw == code_cmd) begin
          cur_chan = CH_COMMAND;
        end else if (chan_raw == code_data) begin
          cur_chan = CH_DATA;
        end else begin
          fault = ERR_CHANNEL;
        end
        if (fault == ERR_NONE) begin
          if (len_acc > MAX_PAYLOAD) begin
            fault = ERR_TOO_LONG;
          end else if (!hello_ok && cur_chan != CH_HELLO) begin
            fault = ERR_NOT_FIRST;
          end else if (hello_ok && cur_chan == CH_HELLO) begin
            fault = ERR_REPEATED;
          end else if (cur_chan == CH_HELLO && len_acc != HELLO_LEN) begin
            fault = ERR_HELLO_LEN;
          end else if (len_acc == '0) begin
            hdr_cnt = HDR_FIRST;
            r.frame_end = 1'b1;
          end else begin
            left_cnt = len_acc[LEFT_W-1:0];
          end
        end
      end
    end else begin
      // payload phase
      if (cur_chan == CH_HELLO && b != want_ver) begin
        fault = ERR_VERSION;
      end else begin
        if (left_cnt != '0) begin
          left_cnt = left_cnt - 1'b1;
        end
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        if (left_cnt == '0) begin
          hdr_cnt = HDR_FIRST;
          if (cur_chan == CH_HELLO) begin
            hello_ok = 1'b1;
          end
          r.frame_end = 1'b1;
        end
      end
    end
    // errors stick until reset
    if (fault != ERR_NONE) begin
      dead = 1'b1;
      dead_code = fault;
      r.kind = KIND_FAILED;
      r.payload_byte = '0;
      r.frame_end = 1'b0;
      r.error_code = fault;
    end
    r.frame_channel = cur_chan;
    r.hello_seen = hello_ok;
  endtask

  function automatic int field_bad(string name, int unsigned want_v, int unsigned got_v);
    if (want_v == got_v) begin
      return 0;
    end
    $error("%s: expected %0d, got %0d", name, want_v, got_v);
    return 1;
  endfunction

  // follow the config, input and output channels
  always @(posedge clk) begin
    result_t want;
    result_t got;
    int bad;
    bad = 0;
    if (rst) begin
      code_hello = RST_HELLO_CODE;
      code_cmd = RST_COMMAND_CODE;
      code_data = RST_DATA_CODE;
      want_ver = RST_VERSION;
      hdr_cnt = HDR_FIRST;
      chan_raw = '0;
      len_acc = '0;
      left_cnt = '0;
      cur_chan = CH_COMMAND;
      hello_ok = 1'b0;
      dead = 1'b0;
      dead_code = ERR_NONE;
      due_results.delete();
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HELLO_CODE:   code_hello = cfg_data;
          CFG_COMMAND_CODE: code_cmd = cfg_data;
          CFG_DATA_CODE:    code_data = cfg_data;
          CFG_VERSION:      want_ver = cfg_data;
          default: ;
        endcase
      end
      // accepted byte request
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, want);
        due_results.insert(due_results.size(), want);
      end
      // result request against the oldest owed result
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.frame_channel = m_tdata[1:0];
        got.payload_byte = m_tdata[9:2];
        got.frame_end = m_tlast;
        got.error_code = m_tdata[12:10];
        got.hello_seen = m_tdata[13];
        if (due_results.size() == 0) begin
          $error("result with no byte pending: kind %0d", got.kind);
          bad = 1;
        end else begin
          want = due_results.pop_front();
          bad += field_bad("kind", want.kind, got.kind);
          bad += field_bad("frame_channel", want.frame_channel, got.frame_channel);
          bad += field_bad("payload_byte", want.payload_byte, got.payload_byte);
          bad += field_bad("frame_end", want.frame_end, got.frame_end);
          bad += field_bad("error_code", want.error_code, got.error_code);
          bad += field_bad("hello_seen", want.hello_seen, got.hello_seen);
        end
      end
      fail_count <= fail_count + bad;
      outstanding <= due_results.size();
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
  import tlfd_pkg::*;

  localparam int unsigned MAX_PAYLOAD = 65536;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int LONG_PHASE = 3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_HELLO_CODE;
  logic [7:0]           cfg_data = '0;

  int fail_count;
  int outstanding;
  int cycles = 0;
  int sent = 0;
  int burst_left = 0;
  int stall_left = 0;
  logic steady = 1'b0;

  // channel codes the block holds now
  logic [7:0] hc = RST_HELLO_CODE;
  logic [7:0] cc = RST_COMMAND_CODE;
  logic [7:0] dc = RST_DATA_CODE;

  always #4 clk = ~clk;

  type_length_frame_deframer_unit #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  deframe_monitor #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_monitor (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // receiver: toggles ready with random run and stall lengths, always ready when steady
  always @(posedge clk) begin
    if (steady) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= !m_tready;
      stall_left <= m_tready ? $urandom_range(0, 3) : $urandom_range(0, 7);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one byte request, with a random gap between bursts when not steady
  task automatic put_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata <= b;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_header(input logic [7:0] chan, input logic [31:0] len);
    put_byte(chan);
    put_byte(len[31:24]);
    put_byte(len[23:16]);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
  endtask

  task automatic send_frame(input logic [7:0] chan, input logic [31:0] len);
    int unsigned n;
    send_header(chan, len);
    for (n = 0; n < len; n++) begin
      put_byte(8'($urandom));
    end
  endtask

  // stop sending and wait until every owed result has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers while the block is idle
  task automatic load_codes(input logic [7:0] h, input logic [7:0] c,
                            input logic [7:0] d, input logic [7:0] v);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [7:0] vals[4];
    int i;
    settle();
    idx = '{CFG_HELLO_CODE, CFG_COMMAND_CODE, CFG_DATA_CODE, CFG_VERSION};
    vals = '{h, c, d, v};
    for (i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    hc = h;
    cc = c;
    dc = d;
  endtask

  // command or data code that is not shadowed by the hello code
  function automatic logic [7:0] pick_channel();
    logic [7:0] ch;
    ch = $urandom_range(0, 1) ? cc : dc;
    if (ch == hc) begin
      ch = (ch == cc) ? dc : cc;
    end
    return ch;
  endfunction

  initial begin
    logic [7:0] h, c, d, v, chan;
    logic [31:0] len;
    logic early;
    int phase;
    int phase_end;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // now and then break the stream before the hello has passed
    early = ($urandom_range(0, 7) == 0);
    if (early) begin
      case ($urandom_range(0, 2))
        0: send_frame($urandom_range(0, 1) ? RST_COMMAND_CODE : RST_DATA_CODE,
                      $urandom_range(0, 3));
        1: send_header(RST_HELLO_CODE, $urandom_range(0, 1) ? 32'd0 : $urandom_range(2, 300));
        default: begin
          v = 8'($urandom);
          while (v == RST_VERSION) v = 8'($urandom);
          send_header(RST_HELLO_CODE, HELLO_LEN);
          put_byte(v);
        end
      endcase
    end

    // directed frames at the reset codes
    send_header(RST_HELLO_CODE, HELLO_LEN);
    put_byte(RST_VERSION);
    send_frame(RST_COMMAND_CODE, 32'd0);
    send_header(RST_DATA_CODE, 32'd2);
    put_byte(8'hFF);
    put_byte(8'h00);
    send_header(RST_COMMAND_CODE, 32'd1);
    put_byte(8'hA5);

    // random frames under several code settings
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          h = 8'hFF; c = 8'h00; d = 8'h7F; v = 8'h00;
        end
        1: begin
          // command and data share a code
          h = 8'h00; c = 8'hFF; d = 8'hFF; v = 8'hFF;
        end
        2: begin
          // hello shadows the command code
          h = 8'($urandom); c = h; d = 8'($urandom); v = 8'($urandom);
          while (d == h) d = 8'($urandom);
        end
        default: begin
          h = 8'($urandom); c = 8'($urandom); d = 8'($urandom); v = 8'($urandom);
          while (c == h && d == h) c = 8'($urandom);
        end
      endcase
      load_codes(h, c, d, v);
      steady <= (phase == LONG_PHASE) || ($urandom_range(0, 3) == 0);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        send_frame(pick_channel(), len);
      end
    end

    // one broken header at the end unless the stream broke early, then noise into the failed decoder
    if (!early) begin
      case ($urandom_range(0, 2))
        0: begin
          chan = 8'($urandom);
          while (chan == hc || chan == cc || chan == dc) chan = 8'($urandom);
          send_header(chan, $urandom);
        end
        1: begin
          case ($urandom_range(0, 2))
            0: chan = hc;
            1: chan = cc;
            default: chan = dc;
          endcase
          len = $urandom_range(0, 1) ? MAX_PAYLOAD + 1 : ($urandom | 32'h8000_0000);
          send_header(chan, len);
        end
        default: send_header(hc, $urandom_range(0, 3));
      endcase
    end
    repeat ($urandom_range(20, 40)) put_byte(8'($urandom));

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* type_length_frame_deframer_unit.f */
sv/tlfd_pkg.sv
sv/tlfd_stage.sv
sv/tlfd_parse.sv
sv/type_length_frame_deframer_unit.sv
sv/tlfd_checker.sv
verif/deframe_monitor.sv
verif/tb.sv
